// ===== rtl/core/btmx_pkg.sv =====
// Shared codes, defaults and command and status structures for the binary trie maximum-XOR block.
package btmx_pkg;

  localparam int NODE_COUNT_DEF = 4096;
  localparam int KEY_BITS_DEF   = 32;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       step;
    logic       ins;
    logic       publish;
    logic [1:0] pub_status;
  } btmx_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic stop;
  } btmx_sts_t;

endpackage

// ===== rtl/core/btmx_dp.sv =====
// Datapath of the trie: root links, node pool memory, walk registers and result register.
module btmx_dp #(
  parameter int NODE_COUNT = btmx_pkg::NODE_COUNT_DEF,
  parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF,
  localparam int LW        = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          in_key_value,
  input  btmx_pkg::btmx_cmd_t  cmd,
  input  logic [LW-1:0]        lvl,
  output btmx_pkg::btmx_sts_t  sts,
  output logic [31:0]          out_best_xor,
  output logic [1:0]           out_status
);
  import btmx_pkg::*;

  localparam int NW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int EW = 2 * NW;

  logic [EW-1:0]         mem [NODE_COUNT];
  logic [EW-1:0]         rd_data_r;
  logic [NW-1:0]         rd_addr;
  logic                  mem_we;
  logic [NW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;

  logic [NW-1:0]         root0_r, root0_nxt;
  logic [NW-1:0]         root1_r, root1_nxt;
  logic [NW-1:0]         cur_r, cur_nxt;
  logic [CW-1:0]         used_r, used_nxt;
  logic                  fresh_r, fresh_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [KEY_BITS-1:0]   best_r, best_nxt;
  logic [KEY_BITS+31:0]  key_ext;
  logic [KEY_BITS+31:0]  best_ext;

  logic [EW-1:0]         pair;
  logic [EW-1:0]         pair_eff;
  logic [EW-1:0]         pair_upd;
  logic [NW-1:0]         link0, link1, same, opp, new_node;
  logic                  kbit;

  logic [31:0]           out_best_r;
  logic [1:0]            out_status_r;

  // A node allocated earlier in the same insert has no children yet, so its links read as null.
  always_comb begin
    key_ext  = {KEY_BITS'(0), in_key_value};
    best_ext = {32'(0), best_r};
    pair     = (cur_r == '0) ? {root1_r, root0_r} : rd_data_r;
    pair_eff = fresh_r ? '0 : pair;
    link0    = pair_eff[NW-1:0];
    link1    = pair_eff[EW-1:NW];
    kbit     = key_r[lvl];
    same     = kbit ? link1 : link0;
    opp      = kbit ? link0 : link1;
    new_node = used_r[NW-1:0];
    pair_upd = kbit ? {new_node, link0} : {link1, new_node};

    sts.full  = (CW'(NODE_COUNT) - used_r) < CW'(KEY_BITS);
    sts.empty = (root0_r == '0) && (root1_r == '0);
    sts.stop  = !cmd.ins && (opp == '0) && (same == '0);
  end

  always_comb begin
    root0_nxt = root0_r;
    root1_nxt = root1_r;
    cur_nxt   = cur_r;
    used_nxt  = used_r;
    fresh_nxt = fresh_r;
    key_nxt   = key_r;
    best_nxt  = best_r;
    mem_we    = 1'b0;
    wr_addr   = cur_r;
    wr_data   = pair_upd;

    if (cmd.load) begin
      key_nxt   = key_ext[KEY_BITS-1:0];
      cur_nxt   = '0;
      fresh_nxt = 1'b0;
      best_nxt  = '0;
    end
    if (cmd.clear) begin
      root0_nxt = '0;
      root1_nxt = '0;
      used_nxt  = CW'(1);
    end
    if (cmd.step) begin
      if (cmd.ins) begin
        if (same == '0) begin
          cur_nxt   = new_node;
          used_nxt  = used_r + CW'(1);
          fresh_nxt = 1'b1;
          if (cur_r == '0) begin
            if (kbit) begin
              root1_nxt = new_node;
            end else begin
              root0_nxt = new_node;
            end
          end else begin
            mem_we = 1'b1;
          end
        end else begin
          cur_nxt = same;
        end
      end else if (opp != '0) begin
        cur_nxt       = opp;
        best_nxt[lvl] = 1'b1;
      end else begin
        cur_nxt = same;
      end
    end
  end

  assign rd_addr = cur_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root0_r <= '0;
      root1_r <= '0;
      used_r  <= CW'(1);
      fresh_r <= 1'b0;
    end else begin
      root0_r <= root0_nxt;
      root1_r <= root1_nxt;
      used_r  <= used_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    key_r  <= key_nxt;
    best_r <= best_nxt;
    if (cmd.publish) begin
      out_best_r   <= best_ext[31:0];
      out_status_r <= cmd.pub_status;
    end
  end

  assign out_best_xor = out_best_r;
  assign out_status   = out_status_r;

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r >= CW'(1)) && (used_r <= CW'(NODE_COUNT)))
    else $error("Node count has left its legal range.");

  a_fresh_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r |-> (cur_r == NW'(used_r - CW'(1))))
    else $error("A freshly allocated node is not the most recent allocation.");

endmodule

// ===== rtl/core/btmx_ctrl.sv =====
// Controller state machine: sequences accept, per-level walk and result transfer.
module btmx_ctrl #(
  parameter int KEY_BITS = btmx_pkg::KEY_BITS_DEF,
  localparam int LW      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_kind,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  btmx_pkg::btmx_sts_t  sts,
  output btmx_pkg::btmx_cmd_t  cmd,
  output logic [LW-1:0]        lvl
);
  import btmx_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic          ins_r, ins_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt      = state_r;
    lvl_nxt        = lvl_r;
    ins_nxt        = ins_r;
    status_nxt     = status_r;
    cmd            = '0;
    cmd.ins        = ins_r;
    cmd.pub_status = status_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          lvl_nxt    = LW'(KEY_BITS - 1);
          ins_nxt    = (in_kind == KIND_INSERT);
          status_nxt = ST_OK;
          state_nxt  = S_FIN;
          case (in_kind)
            KIND_INSERT: begin
              if (sts.full) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_WALK;
              end
            end
            KIND_QUERY: begin
              if (sts.empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_WALK;
              end
            end
            KIND_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if ((lvl_r == '0) || sts.stop) begin
          state_nxt = S_FIN;
        end else begin
          lvl_nxt = lvl_r - LW'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = cmd.publish || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lvl_r       <= '0;
      ins_r       <= 1'b0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      ins_r       <= ins_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign lvl       = lvl_r;

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("A result appeared without passing through the finish state.");

  a_level_descends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_WALK) && ($past(state_r) == S_WALK)) |->
      (lvl_r == $past(lvl_r) - LW'(1)))
    else $error("The walk did not descend exactly one level.");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) && in_valid) |=> (state_r != S_IDLE))
    else $error("An accepted item did not start processing.");

endmodule

// ===== rtl/core/binary_trie_max_xor.sv =====
// Top level of the binary trie maximum-XOR block: controller plus datapath.
// An insert or query is accepted in the idle state and then descends the trie in the walk
// state, one level per node pool read; its result is offered from the finish state. Clear,
// rejected and empty items go straight to the finish state. A new item is taken only while
// idle; a stalled result holds the next item in the finish state until it is transferred.
// Reset empties the trie and clears the handshakes; the node pool itself is not cleared,
// as a newly allocated node reads as having no children until its first link is written.
module binary_trie_max_xor #(
  parameter int NODE_COUNT = btmx_pkg::NODE_COUNT_DEF,
  parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_key_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_best_xor,
  output logic [1:0]  out_status
);
  import btmx_pkg::*;

  localparam int LW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  btmx_cmd_t     cmd;
  btmx_sts_t     sts;
  logic [LW-1:0] lvl;

  btmx_ctrl #(
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .lvl       (lvl)
  );

  btmx_dp #(
    .NODE_COUNT (NODE_COUNT),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_key_value (in_key_value),
    .cmd          (cmd),
    .lvl          (lvl),
    .sts          (sts),
    .out_best_xor (out_best_xor),
    .out_status   (out_status)
  );

endmodule
